@@ sv/skc_pkg.sv @@
// Shared constants and types for the soft-knee compressor gain unit.
package skc_pkg;

	localparam int SAMPLE_BITS = 16;
	localparam int DB_BITS     = 16;
	localparam int RATIO_BITS  = 11;
	localparam int KNEE_BITS   = 14;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RATIO     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KNEE      = 2'd2;

	localparam logic [DB_BITS-1:0]    THRESHOLD_RST = 16'hEC00; // -5120
	localparam logic [RATIO_BITS-1:0] RATIO_RST     = 11'd64;
	localparam logic [KNEE_BITS-1:0]  KNEE_RST      = 14'd0;
	localparam logic [RATIO_BITS-1:0] RATIO_UNITY   = 11'd16;

	// log2 front end
	localparam int P_BITS    = $clog2(SAMPLE_BITS);
	localparam int MANT_BITS = 31;
	localparam int LOG_ITERS = 16;
	localparam int DB_PER_LOG2_BITS = 27;
	localparam logic [DB_PER_LOG2_BITS-1:0] DB_PER_LOG2 = 27'd101008905;
	localparam int LEVEL_FLOOR = -25600;

	// gain divider
	localparam int DIV_BITS = 17;
	localparam int ATT_BITS = 15;
	localparam logic [ATT_BITS-1:0] ATT_MAX = 15'd25600;

	// exponential back end
	localparam int LOG2_PER_UNIT_BITS = 22;
	localparam logic [LOG2_PER_UNIT_BITS-1:0] LOG2_PER_UNIT = 22'd2786635;
	localparam int EXP_ITERS = 16;
	localparam int SQRT_BITS = 31;
	localparam int LIN_BITS  = 31;

	localparam int LEVEL_LAT = 1 + LOG_ITERS + 2;
	localparam int GAIN_LAT  = 4 + DIV_BITS + 1;
	localparam int EXP_LAT   = 2 + EXP_ITERS * SQRT_BITS + 1;
	localparam int OUT_LAT   = 2;
	localparam int LATENCY   = LEVEL_LAT + GAIN_LAT + EXP_LAT + OUT_LAT;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] smp;
		logic [DB_BITS-1:0]     gain;
	} exp_side_t;

endpackage

@@ sv/skc_level.sv @@
// Envelope to level in 1/256 dB: log2 by repeated squaring, then dB scaling.
module skc_level (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_vld,
	input  logic [skc_pkg::SAMPLE_BITS-1:0]        env,
	input  logic [skc_pkg::SAMPLE_BITS-1:0]        smp_in,
	output logic                                   out_vld,
	output logic signed [skc_pkg::DB_BITS-1:0]     level,
	output logic [skc_pkg::SAMPLE_BITS-1:0]        smp_out
);
	localparam int SB  = skc_pkg::SAMPLE_BITS;
	localparam int PW  = skc_pkg::P_BITS;
	localparam int MW  = skc_pkg::MANT_BITS;
	localparam int NI  = skc_pkg::LOG_ITERS;
	localparam int KW  = skc_pkg::DB_PER_LOG2_BITS;
	localparam int DW  = skc_pkg::DB_BITS;
	localparam int LQW = PW + 1 + NI;
	localparam int LPW = LQW + KW + 1;
	localparam int LVW = LPW - 32;
	localparam logic signed [LPW-1:0] RND = LPW'(1) << 31;
	localparam logic signed [LVW-1:0] FLOOR_W = LVW'(skc_pkg::LEVEL_FLOOR);

	typedef struct packed {
		logic [MW-1:0] m;
		logic [NI-1:0] frac;
		logic [PW:0]   pexp;
		logic          zero;
		logic [SB-1:0] smp;
	} sq_stage_t;

	logic [PW-1:0]         p_c;
	logic [SB+MW-1:0]      shl_c;
	sq_stage_t             first_c;
	sq_stage_t             sq_s [0:NI];
	logic                  sq_vld_s [0:NI];
	logic signed [LQW-1:0] lq_c;
	logic signed [LPW-1:0] lprod_s17;
	logic                  zero_s17;
	logic [SB-1:0]         smp_s17;
	logic                  vld_s17;
	logic signed [LPW-1:0] lsum_c;
	logic signed [LVW-1:0] lvw_c;
	logic signed [DW-1:0]  level_s18;
	logic [SB-1:0]         smp_s18;
	logic                  vld_s18;

	always_comb begin
		p_c = '0;
		for (int i = 1; i < SB; i++) begin
			if (env[i]) begin
				p_c = PW'(i);
			end
		end
		shl_c         = {env, {MW{1'b0}}} >> ((PW+1)'(p_c) + (PW+1)'(1));
		first_c.m     = shl_c[MW-1:0];
		first_c.frac  = '0;
		first_c.pexp  = (PW+1)'(p_c) - (PW+1)'(SB-1);
		first_c.zero  = (env == '0);
		first_c.smp   = smp_in;
	end

	always_ff @(posedge clk) begin
		sq_s[0] <= first_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else begin
			sq_vld_s[0] <= in_vld;
		end
	end

	for (genvar k = 0; k < NI; k++) begin : g_sq
		logic [2*MW-1:0] prod_c;
		logic [MW:0]     m2_c;
		sq_stage_t       nxt_c;

		always_comb begin
			prod_c = sq_s[k].m * sq_s[k].m;
			m2_c   = prod_c[2*MW-1:MW-1];
			nxt_c  = sq_s[k];
			if (m2_c[MW]) begin
				nxt_c.m    = m2_c[MW:1];
				nxt_c.frac = {sq_s[k].frac[NI-2:0], 1'b1};
			end else begin
				nxt_c.m    = m2_c[MW-1:0];
				nxt_c.frac = {sq_s[k].frac[NI-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			sq_s[k+1] <= nxt_c;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end
	end

	assign lq_c = $signed({sq_s[NI].pexp, sq_s[NI].frac});

	always_ff @(posedge clk) begin
		lprod_s17 <= lq_c * $signed({1'b0, skc_pkg::DB_PER_LOG2});
		zero_s17  <= sq_s[NI].zero;
		smp_s17   <= sq_s[NI].smp;
	end

	assign lsum_c = lprod_s17 + RND;
	assign lvw_c  = lsum_c[LPW-1:32];

	always_ff @(posedge clk) begin
		if (zero_s17 || (lvw_c < FLOOR_W)) begin
			level_s18 <= FLOOR_W[DW-1:0];
		end else begin
			level_s18 <= lvw_c[DW-1:0];
		end
		smp_s18 <= smp_s17;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s17 <= 1'b0;
			vld_s18 <= 1'b0;
		end else begin
			vld_s17 <= sq_vld_s[NI];
			vld_s18 <= vld_s17;
		end
	end

	assign out_vld = vld_s18;
	assign level   = level_s18;
	assign smp_out = smp_s18;

endmodule

@@ sv/skc_exp.sv @@
// Attenuation in 1/256 dB to Q30 linear gain: halvings and square-root steps.
module skc_exp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_vld,
	input  logic [skc_pkg::ATT_BITS-1:0]       att,
	input  skc_pkg::exp_side_t                 side_in,
	output logic                               out_vld,
	output logic [skc_pkg::LIN_BITS-1:0]       lin,
	output skc_pkg::exp_side_t                 side_out
);
	localparam int EW = skc_pkg::ATT_BITS;
	localparam int KW = skc_pkg::LOG2_PER_UNIT_BITS;
	localparam int PW = EW + KW;
	localparam int XW = PW + 1 - 16;
	localparam int NI = skc_pkg::EXP_ITERS;
	localparam int SQ = skc_pkg::SQRT_BITS;
	localparam int RW = 2 * SQ;
	localparam int NS = NI * SQ;
	localparam int LW = skc_pkg::LIN_BITS;

	typedef struct packed {
		logic [RW-1:0]      rem;
		logic [SQ-1:0]      root;
		logic [NI-1:0]      exf;
		logic [XW-NI-1:0]   n;
		skc_pkg::exp_side_t side;
	} step_t;

	logic [PW-1:0]      eprod_s1;
	skc_pkg::exp_side_t side_s1;
	logic               vld_s1;
	logic [PW:0]        esum_c;
	logic [XW-1:0]      ex_c;
	step_t              init_c;
	step_t              st_s [0:NS];
	logic               st_vld_s [0:NS];
	logic [LW-1:0]      lin_sf;
	skc_pkg::exp_side_t side_sf;
	logic               vld_sf;

	always_ff @(posedge clk) begin
		eprod_s1 <= att * skc_pkg::LOG2_PER_UNIT;
		side_s1  <= side_in;
	end

	always_comb begin
		esum_c      = (PW+1)'(eprod_s1) + (PW+1)'(32768);
		ex_c        = esum_c[PW:16];
		init_c.rem  = '0;
		init_c.root = SQ'(1) << (SQ - 1);
		init_c.exf  = ex_c[NI-1:0];
		init_c.n    = ex_c[XW-1:NI];
		init_c.side = side_s1;
	end

	always_ff @(posedge clk) begin
		st_s[0] <= init_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			st_vld_s[0] <= 1'b0;
		end else begin
			vld_s1      <= in_vld;
			st_vld_s[0] <= vld_s1;
		end
	end

	for (genvar it = 0; it < NI; it++) begin : g_it
		for (genvar j = 0; j < SQ; j++) begin : g_bit
			localparam int B = SQ - 1 - j;
			localparam int K = it * SQ + j;
			step_t         cur_c;
			step_t         nxt_c;
			logic [RW-1:0] trial_c;

			always_comb begin
				cur_c = st_s[K];
				if (j == 0) begin
					if (st_s[K].exf[it]) begin
						cur_c.root = st_s[K].root >> 1;
					end
					cur_c.rem  = RW'(cur_c.root) << (SQ - 1);
					cur_c.root = '0;
				end
				trial_c = (RW'(cur_c.root) << (B + 1)) | (RW'(1) << (2 * B));
				nxt_c   = cur_c;
				if (cur_c.rem >= trial_c) begin
					nxt_c.rem     = cur_c.rem - trial_c;
					nxt_c.root[B] = 1'b1;
				end
			end

			always_ff @(posedge clk) begin
				st_s[K+1] <= nxt_c;
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					st_vld_s[K+1] <= 1'b0;
				end else begin
					st_vld_s[K+1] <= st_vld_s[K];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_s[NS].n >= (XW-NI)'(SQ)) begin
			lin_sf <= '0;
		end else begin
			lin_sf <= LW'(st_s[NS].root >> st_s[NS].n);
		end
		side_sf <= st_s[NS].side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sf <= 1'b0;
		end else begin
			vld_sf <= st_vld_s[NS];
		end
	end

	assign out_vld  = vld_sf;
	assign lin      = lin_sf;
	assign side_out = side_sf;

endmodule

@@ sv/soft_knee_compressor_gain_unit.sv @@
// Top level of the soft-knee compressor gain unit.
//
//  channel   | signals                                   | timing
//  ----------+-------------------------------------------+------------------------------
//  input     | start, busy, envelope, sample             | taken when start && !busy
//  result    | done, out_sample, gain_change_db          | one cycle strobe, no backpressure
//  config    | wr_en, wr_index, wr_data                  | written on any edge with wr_en
//
// One transaction per clock; busy is never raised.
// Pipeline depth is set by the 16 x 31 square-root
// steps of the exponential, the 16 squaring stages of the log and the 17-bit divider.
// Reset clears the valid chain and loads the register defaults.
module soft_knee_compressor_gain_unit (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	output logic                                      busy,
	input  logic [skc_pkg::SAMPLE_BITS-1:0]           envelope,
	input  logic signed [skc_pkg::SAMPLE_BITS-1:0]    sample,
	input  logic                                      wr_en,
	input  logic [skc_pkg::CFG_IDX_BITS-1:0]          wr_index,
	input  logic [skc_pkg::DB_BITS-1:0]               wr_data,
	output logic                                      done,
	output logic signed [skc_pkg::SAMPLE_BITS-1:0]    out_sample,
	output logic signed [skc_pkg::DB_BITS-1:0]        gain_change_db
);
	localparam int SB   = skc_pkg::SAMPLE_BITS;
	localparam int DW   = skc_pkg::DB_BITS;
	localparam int RTW  = skc_pkg::RATIO_BITS;
	localparam int KNW  = skc_pkg::KNEE_BITS;
	localparam int UW   = KNW + 1;
	localparam int AW   = 2 * UW;
	localparam int NNW  = AW + RTW;
	localparam int WRW  = KNW + RTW;
	localparam int DNW  = WRW + 3;
	localparam int NUMW = NNW + 2;
	localparam int D2W  = DNW + 1;
	localparam int QW   = skc_pkg::DIV_BITS;
	localparam int CW   = D2W + QW;
	localparam int EW   = skc_pkg::ATT_BITS;
	localparam int LW   = skc_pkg::LIN_BITS;
	localparam int MPW  = SB + LW;
	localparam int OMW  = SB + 2;
	localparam logic signed [SB+2:0] SMAX = {4'b0000, {(SB-1){1'b1}}};
	localparam logic signed [SB+2:0] SMIN = {4'b1111, {(SB-1){1'b0}}};

	typedef struct packed {
		logic [NUMW-1:0] rem;
		logic [QW-1:0]   q;
		logic [D2W-1:0]  den2;
		logic            zero;
		logic [SB-1:0]   smp;
	} dv_stage_t;

	logic signed [DW-1:0] threshold_q;
	logic [RTW-1:0]       ratio_q;
	logic [KNW-1:0]       knee_q;

	logic                 lvl_vld;
	logic signed [DW-1:0] lvl;
	logic [SB-1:0]        lvl_smp;

	logic signed [DW+1:0] x2_c, t2_c, hi_c, lo_c, u_c;
	logic signed [DW:0]   d_c;
	logic [RTW-1:0]       r_c;

	logic                 vld_s1, above_s1, knee_s1;
	logic [DW:0]          d_s1;
	logic [UW-1:0]        u_s1;
	logic [RTW-1:0]       r_s1, rm_s1;
	logic [KNW-1:0]       w_s1;
	logic [SB-1:0]        smp_s1;

	logic                 vld_s2, above_s2, knee_s2;
	logic [AW-1:0]        a_s2;
	logic [WRW-1:0]       wr_s2;
	logic [RTW-1:0]       r_s2, rm_s2;
	logic [SB-1:0]        smp_s2;

	logic                 vld_s3, zero_s3;
	logic [NNW-1:0]       n_s3;
	logic [DNW-1:0]       den_s3;
	logic [SB-1:0]        smp_s3;

	dv_stage_t            dv_s [0:QW];
	logic                 dv_vld_s [0:QW];

	logic [EW-1:0]        att_c;
	logic [EW-1:0]        att_s5;
	skc_pkg::exp_side_t   side_s5;
	logic                 vld_s5;

	logic                 exp_vld;
	logic [LW-1:0]        exp_lin;
	skc_pkg::exp_side_t   exp_side;

	logic [SB-1:0]        mag_c;
	logic [MPW-1:0]       mprod_s6;
	logic                 neg_s6;
	logic [DW-1:0]        gain_s6;
	logic                 vld_s6;

	logic [MPW:0]         osum_c;
	logic [OMW-1:0]       om_c;
	logic signed [SB+2:0] o_c;

	logic                 done_q;
	logic [SB-1:0]        out_sample_q;
	logic [DW-1:0]        gain_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= skc_pkg::THRESHOLD_RST;
			ratio_q     <= skc_pkg::RATIO_RST;
			knee_q      <= skc_pkg::KNEE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				skc_pkg::REG_THRESHOLD: threshold_q <= wr_data;
				skc_pkg::REG_RATIO:     ratio_q     <= wr_data[RTW-1:0];
				skc_pkg::REG_KNEE:      knee_q      <= wr_data[KNW-1:0];
				default: ;
			endcase
		end
	end

	skc_level u_level (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (start && !busy),
		.env     (envelope),
		.smp_in  (sample),
		.out_vld (lvl_vld),
		.level   (lvl),
		.smp_out (lvl_smp)
	);

	// knee region decode
	always_comb begin
		x2_c = {lvl[DW-1], lvl, 1'b0};
		t2_c = {threshold_q[DW-1], threshold_q, 1'b0};
		hi_c = t2_c + $signed((DW+2)'(knee_q));
		lo_c = t2_c - $signed((DW+2)'(knee_q));
		u_c  = x2_c - lo_c;
		d_c  = {lvl[DW-1], lvl} - {threshold_q[DW-1], threshold_q};
		r_c  = (ratio_q < skc_pkg::RATIO_UNITY) ? skc_pkg::RATIO_UNITY : ratio_q;
	end

	always_ff @(posedge clk) begin
		above_s1 <= x2_c > hi_c;
		knee_s1  <= !(x2_c > hi_c) && (x2_c > lo_c);
		d_s1     <= d_c;
		u_s1     <= u_c[UW-1:0];
		r_s1     <= r_c;
		rm_s1    <= r_c - skc_pkg::RATIO_UNITY;
		w_s1     <= knee_q;
		smp_s1   <= lvl_smp;

		a_s2     <= above_s1 ? AW'(d_s1) : u_s1 * u_s1;
		wr_s2    <= w_s1 * r_s1;
		above_s2 <= above_s1;
		knee_s2  <= knee_s1;
		r_s2     <= r_s1;
		rm_s2    <= rm_s1;
		smp_s2   <= smp_s1;

		n_s3     <= a_s2 * rm_s2;
		den_s3   <= above_s2 ? DNW'(r_s2) : {wr_s2, 3'b000};
		zero_s3  <= !above_s2 && !knee_s2;
		smp_s3   <= smp_s2;

		dv_s[0].rem  <= {n_s3, 1'b0} + NUMW'(den_s3);
		dv_s[0].q    <= '0;
		dv_s[0].den2 <= {den_s3, 1'b0};
		dv_s[0].zero <= zero_s3;
		dv_s[0].smp  <= smp_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			dv_vld_s[0] <= 1'b0;
		end else begin
			vld_s1      <= lvl_vld;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			dv_vld_s[0] <= vld_s3;
		end
	end

	// rounded quotient (2N + D) / 2D, one bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [CW-1:0] cmp_c;
		dv_stage_t     nxt_c;

		always_comb begin
			cmp_c = CW'(dv_s[k].den2) << B;
			nxt_c = dv_s[k];
			if (CW'(dv_s[k].rem) >= cmp_c) begin
				nxt_c.rem  = dv_s[k].rem - cmp_c[NUMW-1:0];
				nxt_c.q[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			dv_s[k+1] <= nxt_c;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end
	end

	always_comb begin
		if (dv_s[QW].zero) begin
			att_c = '0;
		end else if (dv_s[QW].q > QW'(skc_pkg::ATT_MAX)) begin
			att_c = skc_pkg::ATT_MAX;
		end else begin
			att_c = dv_s[QW].q[EW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		att_s5       <= att_c;
		side_s5.smp  <= dv_s[QW].smp;
		side_s5.gain <= DW'(0) - DW'(att_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= dv_vld_s[QW];
		end
	end

	skc_exp u_exp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.att      (att_s5),
		.side_in  (side_s5),
		.out_vld  (exp_vld),
		.lin      (exp_lin),
		.side_out (exp_side)
	);

	assign mag_c = exp_side.smp[SB-1] ? (SB'(0) - exp_side.smp) : exp_side.smp;

	always_ff @(posedge clk) begin
		mprod_s6 <= mag_c * exp_lin;
		neg_s6   <= exp_side.smp[SB-1];
		gain_s6  <= exp_side.gain;
	end

	always_comb begin
		osum_c = (MPW+1)'(mprod_s6) + ((MPW+1)'(1) << 29);
		om_c   = osum_c[MPW:30];
		o_c    = neg_s6 ? ((SB+3)'(0) - (SB+3)'(om_c)) : (SB+3)'(om_c);
	end

	always_ff @(posedge clk) begin
		if (o_c > SMAX) begin
			out_sample_q <= SMAX[SB-1:0];
		end else if (o_c < SMIN) begin
			out_sample_q <= SMIN[SB-1:0];
		end else begin
			out_sample_q <= o_c[SB-1:0];
		end
		gain_q <= gain_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s6 <= exp_vld;
			done_q <= vld_s6;
		end
	end

	assign done           = done_q;
	assign out_sample     = out_sample_q;
	assign gain_change_db = gain_q;

endmodule

@@ sv/skc_checker.sv @@
// Port-level checks for the soft-knee compressor gain unit, bound to the top level.
module skc_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   start,
	input logic                                   busy,
	input logic                                   done,
	input logic signed [skc_pkg::SAMPLE_BITS-1:0] out_sample,
	input logic signed [skc_pkg::DB_BITS-1:0]     gain_change_db
);
	localparam logic [skc_pkg::SAMPLE_BITS-1:0] MOST_NEG =
		{1'b1, {(skc_pkg::SAMPLE_BITS-1){1'b0}}};

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (gain_change_db <= 0 && gain_change_db >= skc_pkg::LEVEL_FLOOR))
		else $error("gain change out of range");

	a_attenuated: assert property (@(posedge clk) disable iff (!arst_n)
		(done && gain_change_db != 0) |-> (out_sample != MOST_NEG))
		else $error("attenuated sample at full negative scale");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, skc_pkg::LATENCY))
		else $error("result without a transaction at the pipeline latency");

endmodule

bind soft_knee_compressor_gain_unit skc_checker u_skc_checker (.*);

@@ dv/soft_knee_compressor_gain_unit_tb.sv @@
// Self-checking testbench for the soft-knee compressor gain unit: random and directed stimulus.
module soft_knee_compressor_gain_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [skc_pkg::SAMPLE_BITS-1:0] env;
		logic [skc_pkg::SAMPLE_BITS-1:0] smp;
	} gain_item_t;

	typedef struct packed {
		logic [skc_pkg::SAMPLE_BITS-1:0] smp;
		logic [skc_pkg::DB_BITS-1:0]     gain;
	} gain_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [skc_pkg::SAMPLE_BITS-1:0] envelope = '0;
	logic signed [skc_pkg::SAMPLE_BITS-1:0] sample = '0;
	logic wr_en = 1'b0;
	logic [skc_pkg::CFG_IDX_BITS-1:0] wr_index = skc_pkg::REG_THRESHOLD;
	logic [skc_pkg::DB_BITS-1:0] wr_data = '0;
	logic done;
	logic signed [skc_pkg::SAMPLE_BITS-1:0] out_sample;
	logic signed [skc_pkg::DB_BITS-1:0] gain_change_db;

	soft_knee_compressor_gain_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.envelope(envelope), .sample(sample),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.done(done), .out_sample(out_sample), .gain_change_db(gain_change_db)
	);

	gain_item_t   pending_items[$];
	gain_result_t expected_gains[$];
	logic [skc_pkg::DB_BITS-1:0]    cur_threshold = skc_pkg::THRESHOLD_RST;
	logic [skc_pkg::RATIO_BITS-1:0] cur_ratio = skc_pkg::RATIO_RST;
	logic [skc_pkg::KNEE_BITS-1:0]  cur_knee = skc_pkg::KNEE_RST;
	bit   no_gaps = 1'b0;
	int   gap_left = 0;
	int   errors = 0;
	int   checked = 0;
	int   phases = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint env_to_level(logic [skc_pkg::SAMPLE_BITS-1:0] env);
		longint unsigned ev, m, frac;
		longint lq, lev;
		int p;
		ev = env;
		frac = 0;
		p = 0;
		if (ev == 0)
			return skc_pkg::LEVEL_FLOOR;
		while (p < 63 && (ev >> (p + 1)) != 0)
			p++;
		m = (p <= 30) ? (ev << (30 - p)) : (ev >> (p - 30));
		for (int i = 15; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd1 << 31)) begin
				m >>= 1;
				frac |= 64'd1 << i;
			end
		end
		lq = longint'(p - (skc_pkg::SAMPLE_BITS - 1)) * 65536 + longint'(frac);
		lev = lq * 64'sd101008905 + (64'sd1 <<< 52);
		lev = ((lev + (64'sd1 <<< 31)) >>> 32) - (64'sd1 <<< 20);
		if (lev < skc_pkg::LEVEL_FLOOR)
			lev = skc_pkg::LEVEL_FLOOR;
		return lev;
	endfunction

	function automatic longint unsigned atten_to_linear(longint unsigned e);
		longint unsigned ex, n, y;
		ex = (e * 2786635 + 32768) >> 16;
		n = ex >> 16;
		y = 64'd1 << 30;
		for (int i = 0; i < 16; i++) begin
			if ((ex >> i) & 1)
				y >>= 1;
			y = int_sqrt(y << 30);
		end
		if (n >= 31)
			return 0;
		return y >> n;
	endfunction

	function automatic gain_result_t compress(gain_item_t it);
		gain_result_t res;
		longint x, t, w, r, g, s, o;
		longint unsigned d, u, lin, mag, om;
		x = env_to_level(it.env);
		t = longint'($signed(cur_threshold));
		w = longint'(cur_knee);
		r = longint'(cur_ratio);
		s = longint'($signed(it.smp));
		g = 0;
		if (r < 16)
			r = 16;
		if (2 * x > 2 * t + w) begin
			d = x - t;
			g = -longint'((2 * d * (r - 16) + r) / (2 * r));
		end else if (2 * x > 2 * t - w) begin
			u = 2 * (x - t) + w;
			g = -longint'((2 * u * u * (r - 16) + 8 * w * r) / (16 * w * r));
		end
		if (g < skc_pkg::LEVEL_FLOOR)
			g = skc_pkg::LEVEL_FLOOR;
		lin = atten_to_linear(-g);
		mag = (s < 0) ? -s : s;
		om = (mag * lin + (64'd1 << 29)) >> 30;
		o = (s < 0) ? -longint'(om) : longint'(om);
		if (o > 32767)
			o = 32767;
		if (o < -32768)
			o = -32768;
		res.smp = o[skc_pkg::SAMPLE_BITS-1:0];
		res.gain = g[skc_pkg::DB_BITS-1:0];
		return res;
	endfunction

	// driver
	always @(posedge clk) begin
		logic nxt_start;
		nxt_start = start;
		if (start && !busy) begin
			expected_gains.push_back(compress({envelope, sample}));
			nxt_start = 1'b0;
		end
		if (!start || !busy) begin
			if (gap_left > 0) begin
				gap_left--;
				nxt_start = 1'b0;
			end else if (pending_items.size() != 0 && arst_n) begin
				gain_item_t it;
				it = pending_items.pop_front();
				envelope <= it.env;
				sample <= it.smp;
				nxt_start = 1'b1;
				gap_left = no_gaps ? 0 : $urandom_range(0, 12);
			end
		end
		start <= nxt_start;
	end

	// monitor
	always @(posedge clk) begin
		if (done) begin
			gain_result_t want;
			if (expected_gains.size() == 0) begin
				$display("%0t: unexpected transaction out_sample=%0d gain=%0d",
					$time, out_sample, gain_change_db);
				errors++;
			end else begin
				want = expected_gains.pop_front();
				checked++;
				if (out_sample !== want.smp) begin
					$display("%0t: out_sample expected %0d actual %0d", $time,
						$signed(want.smp), out_sample);
					errors++;
				end
				if (gain_change_db !== want.gain) begin
					$display("%0t: gain_change_db expected %0d actual %0d", $time,
						$signed(want.gain), gain_change_db);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [skc_pkg::CFG_IDX_BITS-1:0] idx,
		logic [skc_pkg::DB_BITS-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		case (idx)
			skc_pkg::REG_THRESHOLD: cur_threshold = val;
			skc_pkg::REG_RATIO:     cur_ratio = val[skc_pkg::RATIO_BITS-1:0];
			default:                cur_knee = val[skc_pkg::KNEE_BITS-1:0];
		endcase
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_config(int thr, int ratio, int knee);
		write_reg(skc_pkg::REG_THRESHOLD, thr[skc_pkg::DB_BITS-1:0]);
		write_reg(skc_pkg::REG_RATIO, ratio[skc_pkg::DB_BITS-1:0]);
		write_reg(skc_pkg::REG_KNEE, knee[skc_pkg::DB_BITS-1:0]);
		phases++;
	endtask

	task automatic wait_idle();
		while (pending_items.size() != 0 || start || expected_gains.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic push(int env, int smp);
		gain_item_t it;
		it.env = env[skc_pkg::SAMPLE_BITS-1:0];
		it.smp = smp[skc_pkg::SAMPLE_BITS-1:0];
		pending_items.push_back(it);
	endtask

	function automatic int rand_env();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 65535);
			1: return $urandom_range(0, 1) ? 0 : (32768 + $urandom_range(0, 1) - 1);
			default: return $urandom_range(0, 65535) >> $urandom_range(0, 15);
		endcase
	endfunction

	initial begin
		int envs[6] = '{0, 1, 32767, 32768, 65535, 1234};
		int smps[4] = '{-32768, 32767, 0, -1};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// reset defaults, hard knee
		foreach (envs[i])
			foreach (smps[j])
				if ((i + j) % 2 == 0 || i == 4)
					push(envs[i], smps[j]);
		wait_idle();
		// extremes, out-of-range and random settings
		for (int k = 0; k < 22; k++) begin
			case (k)
				0: set_config(0, 1024, 12800);
				1: set_config(-25600, 16, 0);
				2: set_config(-25600, 1024, 12800);
				3: set_config(-32768, 1024, 16383);
				4: set_config(32767, 0, 5);
				5: set_config(-2560, 2047, 1);
				6: set_config(-6000, 15, 3000);
				default: set_config($urandom_range(0, 7) == 0 ? $urandom_range(0, 65535)
					: -int'($urandom_range(0, 25600)),
					$urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
					: $urandom_range(16, 1024),
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 16383)
					: $urandom_range(0, 12800));
			endcase
			no_gaps = (k % 4 == 1);
			repeat (72)
				push(rand_env(), $urandom_range(0, 65535));
			wait_idle();
		end
		repeat (skc_pkg::LATENCY + 20) @(posedge clk);
		$display("Checked %0d transactions over %0d register settings, %0d mismatches.",
			checked, phases, errors);
		if (errors == 0 && expected_gains.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("Timeout with %0d transactions outstanding.", expected_gains.size());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
